// ----- rtl/nvbs_pkg.sv -----
package nvbs_pkg;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CNT_W = 11;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LO,
    S_HI,
    S_MID,
    S_PICK,
    S_OUT
  } state_e;

  // for a write word lo carries the table position
  typedef struct packed {
    op_e              op;
    logic [VAL_W-1:0] key;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } item_t;

  // order-preserving unsigned key of a signed value
  function automatic logic [VAL_W-1:0] to_key(input logic signed [VAL_W-1:0] v);
    to_key = {~v[VAL_W-1], v[VAL_W-2:0]};
  endfunction

endpackage

// ----- rtl/nvbs_front.sv -----
module nvbs_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              cmd_i,
  input  logic [nvbs_pkg::IDX_W-1:0]        entry_index_i,
  input  logic signed [nvbs_pkg::VAL_W-1:0] entry_value_i,
  input  logic signed [nvbs_pkg::VAL_W-1:0] query_value_i,
  input  logic [nvbs_pkg::IDX_W-1:0]        low_bound_i,
  input  logic [nvbs_pkg::IDX_W-1:0]        high_bound_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [nvbs_pkg::CNT_W-1:0]        cfg_data_i,
  input  logic                              q_full_i,
  output logic                              q_push_o,
  output nvbs_pkg::item_t                   q_item_o
);

  logic [nvbs_pkg::CNT_W-1:0] entry_count_q;
  logic [nvbs_pkg::IDX_W-1:0] last_idx;
  logic [nvbs_pkg::IDX_W-1:0] hi_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= nvbs_pkg::CNT_W'(1);
    end else if (cfg_valid_i) begin
      entry_count_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // zero counts as one entry, counts past the table saturate
  always_comb begin
    if (entry_count_q == '0) begin
      last_idx = '0;
    end else if (entry_count_q > nvbs_pkg::CNT_W'(nvbs_pkg::DEPTH)) begin
      last_idx = nvbs_pkg::IDX_W'(nvbs_pkg::DEPTH - 1);
    end else begin
      last_idx = nvbs_pkg::IDX_W'(entry_count_q - nvbs_pkg::CNT_W'(1));
    end
  end

  assign hi_sel = (high_bound_i <= low_bound_i) ? last_idx : high_bound_i;

  always_comb begin
    q_item_o = '0;
    if (cmd_i == nvbs_pkg::OP_WRITE) begin
      q_item_o.op  = nvbs_pkg::OP_WRITE;
      q_item_o.key = nvbs_pkg::to_key(entry_value_i);
      q_item_o.lo  = entry_index_i;
    end else begin
      q_item_o.op  = nvbs_pkg::OP_QUERY;
      q_item_o.key = nvbs_pkg::to_key(query_value_i);
      q_item_o.lo  = (low_bound_i > last_idx) ? last_idx : low_bound_i;
      q_item_o.hi  = (hi_sel > last_idx) ? last_idx : hi_sel;
    end
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i;

endmodule

// ----- rtl/nvbs_fifo.sv -----
module nvbs_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  nvbs_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output nvbs_pkg::item_t head_o
);

  nvbs_pkg::item_t slot_q [2];
  logic            wr_ptr_q;
  logic            rd_ptr_q;
  logic [1:0]      count_q;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ----- rtl/nvbs_back.sv -----
module nvbs_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_empty_i,
  input  nvbs_pkg::item_t            q_head_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [nvbs_pkg::IDX_W-1:0] nearest_index_o
);

  logic [nvbs_pkg::VAL_W-1:0] mem_q [nvbs_pkg::DEPTH];
  logic [nvbs_pkg::VAL_W-1:0] rdata_q;
  logic [nvbs_pkg::IDX_W-1:0] raddr;
  logic                       mem_we;

  nvbs_pkg::state_e           state_q, state_d;
  logic [nvbs_pkg::VAL_W-1:0] y_q, y_d;
  logic [nvbs_pkg::VAL_W-1:0] vlo_q, vlo_d;
  logic [nvbs_pkg::VAL_W-1:0] vhi_q, vhi_d;
  logic [nvbs_pkg::IDX_W-1:0] lo_q, lo_d;
  logic [nvbs_pkg::IDX_W-1:0] hi_q, hi_d;
  logic [nvbs_pkg::IDX_W-1:0] mid_q, mid_d;
  logic [nvbs_pkg::IDX_W-1:0] res_q, res_d;
  logic                       out_valid_q;
  logic [nvbs_pkg::IDX_W-1:0] out_idx_q;
  logic                       load_out;
  logic                       slot_free;

  logic                       rd_eq;
  logic                       rd_lt;
  logic [nvbs_pkg::IDX_W-1:0] nlo;
  logic [nvbs_pkg::IDX_W-1:0] nhi;
  logic [nvbs_pkg::IDX_W-1:0] cur_lo;
  logic [nvbs_pkg::IDX_W-1:0] cur_hi;
  logic [nvbs_pkg::IDX_W-1:0] span;
  logic [nvbs_pkg::IDX_W-1:0] mid_next;
  logic                       span_gt1;
  logic [nvbs_pkg::VAL_W-1:0] d_lo;
  logic [nvbs_pkg::VAL_W-1:0] d_hi;

  // table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[q_head_i.lo] <= q_head_i.key;
    end
    rdata_q <= mem_q[raddr];
  end

  assign rd_eq = (rdata_q == y_q);
  assign rd_lt = (rdata_q < y_q);
  assign nlo   = rd_lt ? mid_q : lo_q;
  assign nhi   = rd_lt ? hi_q : mid_q;

  // range after this step, and the probe point inside it
  assign cur_lo   = (state_q == nvbs_pkg::S_MID) ? nlo : lo_q;
  assign cur_hi   = (state_q == nvbs_pkg::S_MID) ? nhi : hi_q;
  assign span     = cur_hi - cur_lo;
  assign mid_next = cur_lo + (span >> 1);
  assign span_gt1 = (span > nvbs_pkg::IDX_W'(1));

  assign d_lo = y_q - vlo_q;
  assign d_hi = vhi_q - y_q;

  assign slot_free = ~out_valid_q | ~out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      nvbs_pkg::S_IDLE: begin
        if (!q_empty_i && q_head_i.op == nvbs_pkg::OP_QUERY) begin
          state_d = nvbs_pkg::S_LO;
        end
      end
      nvbs_pkg::S_LO: begin
        state_d = (y_q <= rdata_q) ? nvbs_pkg::S_OUT : nvbs_pkg::S_HI;
      end
      nvbs_pkg::S_HI: begin
        if (y_q >= rdata_q) begin
          state_d = nvbs_pkg::S_OUT;
        end else begin
          state_d = span_gt1 ? nvbs_pkg::S_MID : nvbs_pkg::S_PICK;
        end
      end
      nvbs_pkg::S_MID: begin
        if (rd_eq) begin
          state_d = nvbs_pkg::S_OUT;
        end else begin
          state_d = span_gt1 ? nvbs_pkg::S_MID : nvbs_pkg::S_PICK;
        end
      end
      nvbs_pkg::S_PICK: begin
        state_d = nvbs_pkg::S_OUT;
      end
      nvbs_pkg::S_OUT: begin
        if (slot_free) begin
          state_d = nvbs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = nvbs_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop_o  = 1'b0;
    mem_we   = 1'b0;
    raddr    = lo_q;
    load_out = 1'b0;
    y_d      = y_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    vlo_d    = vlo_q;
    vhi_d    = vhi_q;
    mid_d    = mid_q;
    res_d    = res_q;
    case (state_q)
      nvbs_pkg::S_IDLE: begin
        q_pop_o = ~q_empty_i;
        mem_we  = ~q_empty_i & (q_head_i.op == nvbs_pkg::OP_WRITE);
        raddr   = q_head_i.lo;
        y_d     = q_head_i.key;
        lo_d    = q_head_i.lo;
        hi_d    = q_head_i.hi;
      end
      nvbs_pkg::S_LO: begin
        raddr = hi_q;
        res_d = lo_q;
        vlo_d = rdata_q;
      end
      nvbs_pkg::S_HI: begin
        raddr = mid_next;
        res_d = hi_q;
        vhi_d = rdata_q;
        mid_d = mid_next;
      end
      nvbs_pkg::S_MID: begin
        raddr = mid_next;
        res_d = mid_q;
        lo_d  = nlo;
        hi_d  = nhi;
        mid_d = mid_next;
        if (rd_lt) begin
          vlo_d = rdata_q;
        end else begin
          vhi_d = rdata_q;
        end
      end
      nvbs_pkg::S_PICK: begin
        // tie goes to the lower index
        res_d = (d_lo > d_hi) ? hi_q : lo_q;
      end
      nvbs_pkg::S_OUT: begin
        load_out = slot_free;
      end
      default: begin
        raddr = lo_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    y_q   <= y_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    vlo_q <= vlo_d;
    vhi_q <= vhi_d;
    mid_q <= mid_d;
    res_q <= res_d;
    if (load_out) begin
      out_idx_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nvbs_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign nearest_index_o = out_idx_q;

endmodule

// ----- rtl/nearest_value_binary_search_core.sv -----
// channel  direction  handshake                 word
// in       input      in_valid_i / in_stall_o   cmd, entry_index, entry_value, query_value,
//                                               low_bound, high_bound
// out      output     out_valid_o / out_stall_i nearest_index
// cfg      input      cfg_valid_i / cfg_ready_o entry_count
//
// a table write is done by the search engine in its idle state; a query ends after reading the low end
// entry when that entry decides it and after reading the high end entry when that one does, else it
// bisects the range, one table read per cycle through the read port
// a 2-word queue sits between accept and search, so input is taken while a query runs
// reset clears control and sets entry_count to 1; the table is undefined until written
// the result register frees the engine as soon as the word downstream is taken
module nearest_value_binary_search_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              cmd_i,
  input  logic [nvbs_pkg::IDX_W-1:0]        entry_index_i,
  input  logic signed [nvbs_pkg::VAL_W-1:0] entry_value_i,
  input  logic signed [nvbs_pkg::VAL_W-1:0] query_value_i,
  input  logic [nvbs_pkg::IDX_W-1:0]        low_bound_i,
  input  logic [nvbs_pkg::IDX_W-1:0]        high_bound_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [nvbs_pkg::IDX_W-1:0]        nearest_index_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [nvbs_pkg::CNT_W-1:0]        cfg_data_i
);

  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_empty;
  nvbs_pkg::item_t q_item;
  nvbs_pkg::item_t q_head;

  nvbs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .query_value_i (query_value_i),
    .low_bound_i   (low_bound_i),
    .high_bound_i  (high_bound_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_item_o      (q_item)
  );

  nvbs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  nvbs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_head_i        (q_head),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .nearest_index_o (nearest_index_o)
  );

endmodule

// ----- test/tb_top.sv -----
module tb_top;
  import nvbs_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_LEN = 300;
  localparam int unsigned TOP_SPAN = 64;
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct {
    op_e                     cmd;
    logic [IDX_W-1:0]        entry_index;
    logic signed [VAL_W-1:0] entry_value;
    logic signed [VAL_W-1:0] query_value;
    logic [IDX_W-1:0]        low_bound;
    logic [IDX_W-1:0]        high_bound;
  } search_word_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic                    cmd_i = 1'b0;
  logic [IDX_W-1:0]        entry_index_i = '0;
  logic signed [VAL_W-1:0] entry_value_i = '0;
  logic signed [VAL_W-1:0] query_value_i = '0;
  logic [IDX_W-1:0]        low_bound_i = '0;
  logic [IDX_W-1:0]        high_bound_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [IDX_W-1:0]        nearest_index_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CNT_W-1:0]        cfg_data_i = '0;

  // shadow of the table and the count register
  logic signed [VAL_W-1:0] entry_vals [DEPTH];
  logic [CNT_W-1:0]        entry_count = 11'd1;
  logic [IDX_W-1:0]        nearest_expected [$];

  idle_mode_e  idle_mode = IDLE_NONE;
  int unsigned fail_count = 0;
  int unsigned hold_asks = 0;
  int unsigned holds_done = 0;
  int unsigned hold_cycles = 0;
  logic        long_hold = 1'b0;

  nearest_value_binary_search_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .entry_index_i  (entry_index_i),
    .entry_value_i  (entry_value_i),
    .query_value_i  (query_value_i),
    .low_bound_i    (low_bound_i),
    .high_bound_i   (high_bound_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .nearest_index_o(nearest_index_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // flipping the sign bit gives an unsigned key with the same order
  function automatic logic [VAL_W-1:0] key_of(input logic signed [VAL_W-1:0] v);
    return v ^ {1'b1, {(VAL_W-1){1'b0}}};
  endfunction

  function automatic int unsigned last_entry();
    int unsigned n;
    n = 32'(entry_count);
    if (n == 0) n = 1;
    if (n > DEPTH) n = DEPTH;
    return n - 1;
  endfunction

  function automatic logic [IDX_W-1:0] predict_nearest(input logic signed [VAL_W-1:0] qv,
                                                       input logic [IDX_W-1:0] lo_in,
                                                       input logic [IDX_W-1:0] hi_in);
    logic [VAL_W-1:0] y;
    logic [VAL_W-1:0] mid_key;
    int unsigned      last;
    int unsigned      lo;
    int unsigned      hi;
    int unsigned      mid;
    y = key_of(qv);
    last = last_entry();
    lo = 32'(lo_in);
    hi = 32'(hi_in);
    if (hi <= lo) hi = last;
    if (lo > last) lo = last;
    if (hi > last) hi = last;
    if (y <= key_of(entry_vals[lo])) return lo[IDX_W-1:0];
    if (y >= key_of(entry_vals[hi])) return hi[IDX_W-1:0];
    while (hi - lo > 1) begin
      mid = lo + (hi - lo) / 2;
      mid_key = key_of(entry_vals[mid]);
      if (mid_key == y) return mid[IDX_W-1:0];
      if (mid_key < y) lo = mid;
      else hi = mid;
    end
    // ties go to the lower index
    if (y - key_of(entry_vals[lo]) > key_of(entry_vals[hi]) - y) return hi[IDX_W-1:0];
    return lo[IDX_W-1:0];
  endfunction

  // unused fields carry noise
  function automatic search_word_t random_word();
    search_word_t w;
    w.cmd = op_e'($urandom_range(1));
    w.entry_index = IDX_W'($urandom);
    w.entry_value = $urandom;
    w.query_value = $urandom;
    w.low_bound = IDX_W'($urandom);
    w.high_bound = IDX_W'($urandom);
    return w;
  endfunction

  function automatic search_word_t write_word(input logic [IDX_W-1:0] idx,
                                              input logic signed [VAL_W-1:0] val);
    search_word_t w;
    w = random_word();
    w.cmd = OP_WRITE;
    w.entry_index = idx;
    w.entry_value = val;
    return w;
  endfunction

  function automatic search_word_t query_word(input logic signed [VAL_W-1:0] qv,
                                              input logic [IDX_W-1:0] lo,
                                              input logic [IDX_W-1:0] hi);
    search_word_t w;
    w = random_word();
    w.cmd = OP_QUERY;
    w.query_value = qv;
    w.low_bound = lo;
    w.high_bound = hi;
    return w;
  endfunction

  function automatic search_word_t random_query();
    search_word_t w;
    int unsigned  last;
    int unsigned  i;
    int unsigned  lo;
    longint       a;
    longint       b;
    w = query_word($urandom, 0, 0);
    last = last_entry();
    i = $urandom_range(last);
    a = entry_vals[0];
    b = entry_vals[last];
    case ($urandom_range(6))
      0: w.query_value = entry_vals[i];
      1: w.query_value = entry_vals[i] + ($urandom_range(1) ? 1 : -1);
      2: begin
        // midpoint of two neighbors, a tie when their gap is even
        if (i < last) begin
          a = entry_vals[i];
          b = entry_vals[i+1];
        end else begin
          b = a;
        end
        w.query_value = VAL_W'(a + (b - a) / 2);
      end
      3: ;
      4: w.query_value = $urandom_range(1) ? VAL_MAX : VAL_MIN;
      default: begin
        if (b > a) w.query_value = VAL_W'(a + longint'($urandom) % (b - a + 1));
      end
    endcase
    case ($urandom_range(9))
      0: begin
        w.low_bound = IDX_W'($urandom);
        w.high_bound = IDX_W'($urandom);
      end
      1: begin
        lo = $urandom_range(last);
        w.low_bound = IDX_W'(lo);
        w.high_bound = IDX_W'($urandom_range(lo));
      end
      2: begin
        w.low_bound = 0;
        w.high_bound = IDX_W'(last);
      end
      default: begin
        lo = $urandom_range(last);
        w.low_bound = IDX_W'(lo);
        w.high_bound = IDX_W'($urandom_range(lo, last));
      end
    endcase
    return w;
  endfunction

  // searches that stay inside the loaded top end of the table
  function automatic search_word_t top_query();
    search_word_t w;
    int unsigned  i;
    i = $urandom_range(DEPTH - TOP_SPAN, DEPTH - 1);
    w = query_word($urandom, IDX_W'($urandom_range(DEPTH - TOP_SPAN, DEPTH - 1)),
                   IDX_W'($urandom));
    case ($urandom_range(3))
      0: w.query_value = entry_vals[i];
      1: w.query_value = entry_vals[i] + 1;
      default: ;
    endcase
    return w;
  endfunction

  task automatic send_item(input search_word_t w);
    int unsigned idle_pct;
    idle_pct = (idle_mode == IDLE_SENDER) ? 80 : (idle_mode == IDLE_BOTH) ? 13 : 0;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= w.cmd;
    entry_index_i <= w.entry_index;
    entry_value_i <= w.entry_value;
    query_value_i <= w.query_value;
    low_bound_i <= w.low_bound;
    high_bound_i <= w.high_bound;
    do @(posedge clk_i); while (in_stall_o);
    if (w.cmd == OP_WRITE) begin
      entry_vals[w.entry_index] = w.entry_value;
    end else begin
      nearest_expected.insert(nearest_expected.size(),
                              predict_nearest(w.query_value, w.low_bound, w.high_bound));
    end
  endtask

  // writes give no result, so let the engine finish them before going on
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (nearest_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_entry_count(input logic [CNT_W-1:0] n);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= n;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    entry_count = n;
  endtask

  task automatic load_sorted_table(input int unsigned first, input int unsigned n);
    longint      v;
    longint      stride;
    int unsigned i;
    case ($urandom_range(3))
      0: stride = 3;
      1: stride = 1000;
      2: stride = 1 << 20;
      default: stride = 1 << 22;
    endcase
    v = longint'($signed($urandom));
    if (stride * n > 64'd2147483648) v = longint'(VAL_MIN) + $urandom_range(1000);
    for (i = 0; i < n; i++) begin
      send_item(write_word(IDX_W'(first + i), v[VAL_W-1:0]));
      v = v + $urandom_range(stride);
      if (v > longint'(VAL_MAX)) v = VAL_MAX;
    end
  endtask

  task automatic test_directed_cases();
    logic signed [VAL_W-1:0] ladder [8];
    int unsigned             i;
    ladder = '{VAL_MIN, -32'sd1000, -32'sd10, 32'sd0, 32'sd10, 32'sd10, 32'sd2000, VAL_MAX};
    idle_mode = IDLE_NONE;
    // count after reset is one entry
    send_item(write_word(0, VAL_MIN));
    send_item(query_word(VAL_MIN, 0, 0));
    send_item(query_word(VAL_MAX, 1023, 1023));
    wait_idle();
    set_entry_count(8);
    for (i = 0; i < 8; i++) send_item(write_word(i[IDX_W-1:0], ladder[i]));
    send_item(write_word(1023, 0));
    send_item(query_word(VAL_MIN, 0, 7));
    send_item(query_word(VAL_MAX, 0, 7));
    send_item(query_word(0, 0, 7));        // exact hit on a midpoint
    send_item(query_word(-505, 0, 7));     // equal distance, lower wins
    send_item(query_word(-504, 0, 7));
    send_item(query_word(1000, 5, 2));     // end not above start
    send_item(query_word(12, 1023, 1023)); // both bounds past the count
    send_item(query_word(5, 2, 1023));
    send_item(query_word(-1000, 4, 6));
    // break the ordering
    send_item(write_word(3, VAL_MAX));
    send_item(query_word(5, 0, 7));
    wait_idle();
  endtask

  task automatic test_random_traffic();
    search_word_t w;
    int unsigned  n;
    int unsigned  k;
    int unsigned  r;
    int unsigned  last;
    for (int mi = 0; mi < 4; mi++) begin
      for (int s = 0; s < 2; s++) begin
        idle_mode = idle_mode_e'(mi);
        if (mi == 0 && s == 0) n = 1;
        else if (mi == 1 && s == 0) n = 2;
        else if (s == 0) n = $urandom_range(3, 20);
        else n = $urandom_range(21, 40);
        wait_idle();
        set_entry_count(CNT_W'(n));
        load_sorted_table(0, n);
        repeat (45) begin
          r = $urandom_range(99);
          last = last_entry();
          if (r < 75) begin
            w = random_query();
          end else if (r < 88 && last < DEPTH - 1) begin
            w = write_word(IDX_W'($urandom_range(last + 1, DEPTH - 1)), $urandom);
          end else if (r < 98) begin
            k = $urandom_range(last);
            w = write_word(IDX_W'(k), entry_vals[k]);
          end else begin
            k = $urandom_range(last);
            w = write_word(IDX_W'(k), $urandom);
          end
          send_item(w);
        end
      end
    end
    wait_idle();
  endtask

  task automatic test_count_extremes();
    idle_mode = IDLE_BOTH;
    wait_idle();
    set_entry_count(CNT_W'(DEPTH));
    load_sorted_table(DEPTH - TOP_SPAN, TOP_SPAN);
    repeat (30) send_item(top_query());
    send_item(query_word(VAL_MAX, 0, 1023));
    wait_idle();
    // beyond the table depth saturates
    set_entry_count({CNT_W{1'b1}});
    repeat (15) send_item(top_query());
    wait_idle();
    // zero behaves as one entry
    set_entry_count(0);
    repeat (10) send_item(random_query());
    wait_idle();
  endtask

  task automatic test_output_backpressure();
    idle_mode = IDLE_NONE;
    wait_idle();
    set_entry_count(32);
    load_sorted_table(0, 32);
    hold_asks <= hold_asks + 1;
    repeat (40) send_item(random_query());
    wait_idle();
  endtask

  // result checker and receiver stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (nearest_expected.size() == 0) begin
        $error("nearest_index: no result expected, got %0d", nearest_index_o);
        fail_count++;
      end else begin
        if (nearest_index_o !== nearest_expected[0]) begin
          $error("nearest_index: expected %0d, actual %0d",
                 nearest_expected[0], nearest_index_o);
          fail_count++;
        end
        void'(nearest_expected.pop_front());
      end
    end
    out_stall_i <= long_hold ||
                   ($urandom_range(99) < ((idle_mode == IDLE_RECEIVER) ? 80 :
                                          (idle_mode == IDLE_BOTH) ? 13 : 0));
  end

  // long receiver hold so the block backs up into its input
  always @(posedge clk_i) begin
    if (long_hold) begin
      hold_cycles <= hold_cycles + 1;
      if (hold_cycles == HOLD_LEN - 1) long_hold <= 1'b0;
    end else if (hold_asks != holds_done) begin
      long_hold <= 1'b1;
      hold_cycles <= 0;
      holds_done <= holds_done + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_random_traffic();
    test_count_extremes();
    test_output_backpressure();
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- nearest_value_binary_search_core.f -----
rtl/nvbs_pkg.sv
rtl/nvbs_front.sv
rtl/nvbs_fifo.sv
rtl/nvbs_back.sv
rtl/nearest_value_binary_search_core.sv
test/tb_top.sv
